### sv/npcm_pkg.sv
// shared types and constants for the nearest palette color mapper
// no dependencies; used by npcm_cell and nearest_palette_color_mapper_unit
package npcm_pkg;

    localparam int PALETTE_ENTRIES_DEFAULT = 256;

    localparam int IDX_W   = 8;
    localparam int COMP_W  = 8;
    localparam int ALPHA_W = 8;
    // three squared 8-bit differences: 3 * 255 * 255 fits in 18 bits
    localparam int DIST_W  = 18;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_ADDR_W-1:0] REG_MASK_ENABLE     = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_THRESHOLD = 1'd1;

    // item moving down the cell chain, with the running best match
    typedef struct packed {
        logic              cmd;
        logic              masked;
        logic [IDX_W-1:0]  entry_index;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [IDX_W-1:0]  best_idx;
        logic [DIST_W-1:0] best_dist;
    } npcm_item_t;

endpackage

### sv/npcm_cell.sv
// one palette cell: holds one palette entry, takes loads addressed to it
// and folds its distance into the passing pixel's best match; uses npcm_pkg
module npcm_cell #(
    parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEFAULT,
    parameter int CELL_INDEX      = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                mask_enable,
    input  logic                in_valid,
    input  npcm_pkg::npcm_item_t in_item,
    output logic                out_valid,
    output npcm_pkg::npcm_item_t out_item
);
    import npcm_pkg::*;

    localparam logic [IDX_W-1:0] MY_INDEX   = IDX_W'(CELL_INDEX);
    localparam logic             IS_LAST    = (CELL_INDEX == PALETTE_ENTRIES - 1);

    logic [COMP_W-1:0] entry_r_reg, entry_g_reg, entry_b_reg;
    logic [COMP_W-1:0] entry_r_next, entry_g_next, entry_b_next;
    logic              valid_reg, valid_next;
    npcm_item_t        item_reg, item_next;

    logic [COMP_W-1:0]   diff_r, diff_g, diff_b;
    logic [2*COMP_W-1:0] sq_r, sq_g, sq_b;
    logic [DIST_W-1:0]   cand_dist;
    logic                searched;

    always_comb begin
        diff_r = (in_item.red > entry_r_reg) ? in_item.red - entry_r_reg
                                             : entry_r_reg - in_item.red;
        diff_g = (in_item.green > entry_g_reg) ? in_item.green - entry_g_reg
                                               : entry_g_reg - in_item.green;
        diff_b = (in_item.blue > entry_b_reg) ? in_item.blue - entry_b_reg
                                              : entry_b_reg - in_item.blue;
        sq_r = diff_r * diff_r;
        sq_g = diff_g * diff_g;
        sq_b = diff_b * diff_b;
        cand_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
        // the last slot is reserved while masking is on
        searched = !(mask_enable && IS_LAST);
    end

    always_comb begin
        entry_r_next = entry_r_reg;
        entry_g_next = entry_g_reg;
        entry_b_next = entry_b_reg;
        valid_next   = in_valid;
        item_next    = in_item;
        if (in_valid && in_item.cmd == CMD_LOAD && in_item.entry_index == MY_INDEX) begin
            entry_r_next = in_item.red;
            entry_g_next = in_item.green;
            entry_b_next = in_item.blue;
        end
        // strict compare keeps the lowest index on a tie
        if (in_valid && in_item.cmd == CMD_PIXEL && !in_item.masked && searched &&
            cand_dist < in_item.best_dist) begin
            item_next.best_dist = cand_dist;
            item_next.best_idx  = MY_INDEX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            entry_r_reg <= '0;
            entry_g_reg <= '0;
            entry_b_reg <= '0;
        end else if (advance) begin
            valid_reg   <= valid_next;
            entry_r_reg <= entry_r_next;
            entry_g_reg <= entry_g_next;
            entry_b_reg <= entry_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### sv/nearest_palette_color_mapper_unit.sv
// path: from input accept to result through one cell stage per palette entry, then the
// output register; loads travel the same chain and give no result
// throughput: one item per cycle, unless a result at the chain tail meets a full output
// that is not taken, which stalls the chain; reset (aresetn low, synchronous): palette
// entries go to black, config registers to zero, chain and output emptied; no clearing pass
module nearest_palette_color_mapper_unit #(
    parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [npcm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [npcm_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [39:0]                         s_tdata,  // entry_index, red, green, blue, alpha
    input  logic [0:0]                          s_tuser,  // command
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,  // palette index
    output logic [0:0]                          m_tuser   // masked
);
    import npcm_pkg::*;

    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(PALETTE_ENTRIES - 1);

    logic                mask_enable_reg;
    logic [ALPHA_W-1:0]  alpha_threshold_reg;

    logic                chain_valid [0:PALETTE_ENTRIES];
    npcm_item_t          chain_item  [0:PALETTE_ENTRIES];
    logic                advance;
    logic                tail_result;

    logic                m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]    m_index_reg, m_index_next;
    logic                m_masked_reg, m_masked_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_enable_reg     <= 1'b0;
            alpha_threshold_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MASK_ENABLE:     mask_enable_reg     <= cfg_wr_data[0];
                REG_ALPHA_THRESHOLD: alpha_threshold_reg <= cfg_wr_data[ALPHA_W-1:0];
                default:             ;
            endcase
        end
    end

    // head of the chain: unpack, decide masking, seed the search
    always_comb begin
        chain_valid[0]           = s_tvalid;
        chain_item[0].cmd        = s_tuser[0];
        chain_item[0].entry_index = s_tdata[7:0];
        chain_item[0].red        = s_tdata[15:8];
        chain_item[0].green      = s_tdata[23:16];
        chain_item[0].blue       = s_tdata[31:24];
        chain_item[0].masked     = (s_tuser[0] == CMD_PIXEL) && mask_enable_reg &&
                                   (s_tdata[39:32] < alpha_threshold_reg);
        chain_item[0].best_idx   = '0;
        chain_item[0].best_dist  = DIST_MAX;
    end

    genvar k;
    generate
        for (k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
            npcm_cell #(
                .PALETTE_ENTRIES (PALETTE_ENTRIES),
                .CELL_INDEX      (k)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .advance     (advance),
                .mask_enable (mask_enable_reg),
                .in_valid    (chain_valid[k]),
                .in_item     (chain_item[k]),
                .out_valid   (chain_valid[k+1]),
                .out_item    (chain_item[k+1])
            );
        end
    endgenerate

    assign tail_result = chain_valid[PALETTE_ENTRIES] &&
                         (chain_item[PALETTE_ENTRIES].cmd == CMD_PIXEL);
    // the chain only stops when a result sits at the tail and the output is full
    assign advance  = !(tail_result && m_valid_reg && !m_tready);
    assign s_tready = advance;

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_index_next  = m_index_reg;
        m_masked_next = m_masked_reg;
        if (!m_valid_reg || m_tready) begin
            m_valid_next  = tail_result;
            m_masked_next = chain_item[PALETTE_ENTRIES].masked;
            m_index_next  = chain_item[PALETTE_ENTRIES].masked ? LAST_INDEX
                                                               : chain_item[PALETTE_ENTRIES].best_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_index_reg  <= m_index_next;
        m_masked_reg <= m_masked_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_index_reg;
    assign m_tuser[0] = m_masked_reg;

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("chain stalled without a waiting result");

    a_masked_gets_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == LAST_INDEX))
        else $error("masked result not on the last index");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata <= LAST_INDEX))
        else $error("result index beyond the palette");

    a_result_from_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(tail_result))
        else $error("result appeared without a pixel at the chain tail");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// testbench for nearest_palette_color_mapper_unit: palette loads and pixel lookups
// checked against a behavioral nearest-color search; needs npcm_pkg and the unit
module tb;
    import npcm_pkg::*;

    localparam int PALETTE_ENTRIES = 256;
    localparam int CHAIN_LATENCY   = PALETTE_ENTRIES + 1;
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(PALETTE_ENTRIES - 1);

    typedef struct packed {
        logic [IDX_W-1:0] pal_idx;
        logic             masked;
    } mapping_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata     = '0;  // entry_index, red, green, blue, alpha
    logic [0:0]            s_tuser     = '0;  // command
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [7:0]            m_tdata;           // palette index
    logic [0:0]            m_tuser;           // masked

    // shadow of the block's palette and registers
    logic [COMP_W-1:0] pal_red   [PALETTE_ENTRIES];
    logic [COMP_W-1:0] pal_green [PALETTE_ENTRIES];
    logic [COMP_W-1:0] pal_blue  [PALETTE_ENTRIES];
    logic              mask_on     = 1'b0;
    logic [7:0]        alpha_limit = '0;

    mapping_t expected_mappings[$];
    int       fail_count = 0;
    bit       allow_idle = 1'b1;

    nearest_palette_color_mapper_unit #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // nearest entry by squared distance, lowest index on a tie
    function automatic mapping_t map_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [7:0] a);
        mapping_t    res;
        int          searched;
        int unsigned sq_dist;
        int unsigned best_dist;
        int          dr, dg, db;
        res.pal_idx = '0;
        res.masked  = 1'b0;
        if (mask_on && a < alpha_limit) begin
            res.pal_idx = LAST_INDEX;
            res.masked  = 1'b1;
            return res;
        end
        searched  = mask_on ? PALETTE_ENTRIES - 1 : PALETTE_ENTRIES;
        best_dist = 32'hffff_ffff;
        for (int p = 0; p < searched; p++) begin
            dr      = int'(r) - int'(pal_red[p]);
            dg      = int'(g) - int'(pal_green[p]);
            db      = int'(b) - int'(pal_blue[p]);
            sq_dist = unsigned'(dr * dr + dg * dg + db * db);
            if (sq_dist < best_dist) begin
                best_dist   = sq_dist;
                res.pal_idx = IDX_W'(p);
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        mapping_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_mappings.size() == 0) begin
                $error("result with no pixel pending: pal_idx %0d masked %0d",
                       m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = expected_mappings.pop_front();
                if (m_tdata !== want.pal_idx) begin
                    $error("pal_idx: expected %0d, got %0d", want.pal_idx, m_tdata);
                    fail_count++;
                end
                if (m_tuser[0] !== want.masked) begin
                    $error("masked: expected %0d, got %0d", want.masked, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        forever begin
            @(negedge aclk);
            if (allow_idle && aresetn && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] slot, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b, input logic [7:0] a);
        int gap;
        @(negedge aclk);
        if (allow_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {a, b, g, r, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == CMD_LOAD) begin
            pal_red[slot]   = r;
            pal_green[slot] = g;
            pal_blue[slot]  = b;
        end else begin
            expected_mappings.insert(expected_mappings.size(), map_pixel(r, g, b, a));
        end
    endtask

    task automatic wait_results_in();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_mappings.size() != 0) @(posedge aclk);
    endtask

    // loads give no result, so let the chain empty before touching registers
    task automatic settle_chain();
        wait_results_in();
        repeat (CHAIN_LATENCY + 20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == REG_MASK_ENABLE) mask_on = data[0];
        else alpha_limit = data;
    endtask

    task automatic set_config(input logic mask, input logic [7:0] threshold);
        settle_chain();
        // upper bits of the enable write are noise
        write_reg(REG_MASK_ENABLE, {7'($urandom_range(0, 127)), mask});
        write_reg(REG_ALPHA_THRESHOLD, threshold);
    endtask

    function automatic logic [7:0] pick_component();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3) return 8'(($urandom_range(0, 4) * 64 > 255) ? 255
                                : $urandom_range(0, 3) * 64);
        if (roll == 3) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] nudge(logic [7:0] v, int span);
        int n;
        n = int'(v) + $urandom_range(0, 2 * span) - span;
        if (n < 0) n = 0;
        if (n > 255) n = 255;
        return 8'(n);
    endfunction

    task automatic send_random_item();
        logic [7:0] slot, r, g, b, a;
        int         kind;
        int         p;
        kind = $urandom_range(0, 99);
        slot = ($urandom_range(0, 7) == 0) ? LAST_INDEX : 8'($urandom_range(0, 255));
        p    = $urandom_range(0, PALETTE_ENTRIES - 1);
        if ($urandom_range(0, 1)) a = 8'($urandom_range(0, 255));
        else a = nudge(alpha_limit, 2);
        if (kind < 25) begin
            send_item(CMD_LOAD, slot, pick_component(), pick_component(), pick_component(), a);
        end else if (kind < 60) begin
            send_item(CMD_PIXEL, slot, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), a);
        end else if (kind < 85) begin
            r = nudge(pal_red[p], 3);
            g = nudge(pal_green[p], 3);
            b = nudge(pal_blue[p], 3);
            send_item(CMD_PIXEL, slot, r, g, b, a);
        end else if (kind < 92) begin
            send_item(CMD_PIXEL, slot, pal_red[p], pal_green[p], pal_blue[p], a);
        end else begin
            // coarse colors land halfway between coarse entries: ties
            send_item(CMD_PIXEL, slot, pick_component(), pick_component(), pick_component(), a);
        end
    endtask

    // every entry is black after reset, so everything maps to index 0
    task automatic test_reset_palette();
        send_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_item(CMD_PIXEL, 8'd17, 8'd200, 8'd3, 8'd90, 8'd0);
    endtask

    task automatic test_directed_mapping();
        send_item(CMD_LOAD, LAST_INDEX, 8'd255, 8'd255, 8'd255, 8'd0);
        send_item(CMD_LOAD, 8'd1, 8'd255, 8'd0, 8'd0, 8'd255);
        send_item(CMD_LOAD, 8'd2, 8'd0, 8'd255, 8'd0, 8'd0);
        send_item(CMD_LOAD, 8'd3, 8'd0, 8'd0, 8'd255, 8'd0);
        send_item(CMD_LOAD, 8'd4, 8'd128, 8'd128, 8'd128, 8'd0);
        send_item(CMD_LOAD, 8'd5, 8'd128, 8'd128, 8'd128, 8'd0);
        // masking off: alpha ignored, last entry searched
        send_item(CMD_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
        send_item(CMD_PIXEL, 8'd0, 8'd130, 8'd127, 8'd128, 8'd0);
        // equal distance to entries 0 and 4
        send_item(CMD_PIXEL, 8'd0, 8'd64, 8'd64, 8'd64, 8'd0);
        set_config(1'b1, 8'd128);
        // last entry reserved, so white goes elsewhere
        send_item(CMD_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
        send_item(CMD_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'd127);
        send_item(CMD_PIXEL, 8'd0, 8'd0, 8'd255, 8'd0, 8'd128);
        set_config(1'b1, 8'd255);
        send_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd254);
        send_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd250, 8'd255);
        set_config(1'b1, 8'd0);
        send_item(CMD_PIXEL, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_random_mapping();
        logic       mask;
        logic [7:0] threshold;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    mask = 1'b0; threshold = 8'($urandom_range(0, 255));
                end
                1: begin
                    mask = 1'b1; threshold = 8'd0;
                end
                2: begin
                    mask = 1'b1; threshold = 8'd255;
                end
                3: begin
                    mask = 1'b1; threshold = 8'($urandom_range(1, 254));
                end
                default: begin
                    mask = 1'b0; threshold = 8'd255;
                end
            endcase
            set_config(mask, threshold);
            for (int i = 0; i < 230; i++) begin
                if (ph == 0 && i == 115) wait_results_in();
                send_random_item();
            end
        end
    endtask

    task automatic test_back_to_back();
        set_config(1'b1, 8'($urandom_range(1, 254)));
        allow_idle = 1'b0;
        for (int i = 0; i < 200; i++) send_random_item();
    endtask

    initial begin
        for (int p = 0; p < PALETTE_ENTRIES; p++) begin
            pal_red[p]   = '0;
            pal_green[p] = '0;
            pal_blue[p]  = '0;
        end
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_palette();
        test_directed_mapping();
        test_random_mapping();
        test_back_to_back();

        settle_chain();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### nearest_palette_color_mapper_unit.f
sv/npcm_pkg.sv
sv/npcm_cell.sv
sv/nearest_palette_color_mapper_unit.sv
sim/tb.sv
